### design/bsc_pkg.sv
// Shared types, constants and control bundles for the block store compactor.
package bsc_pkg;

    localparam int BLOCKS     = 16;
    localparam int DATA_WIDTH = 16;
    localparam int IDX_W      = $clog2(BLOCKS);
    localparam int CNT_W      = $clog2(BLOCKS + 1);
    localparam int OP_W       = 2;
    localparam int VALUE_W    = 16;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [BLOCKS-1:0]     used_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DEFRAG = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_EMPTY        = 3'd2,
        ST_BAD_POS      = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready;       // input channel may take a beat
        logic dispatch;    // decode latched op, stage status, start walk or pack
        logic walk_step;   // advance the insert walk by one block
        logic walk_write;  // write the value at the walk position
        logic pack_step;   // scan one block during compaction, moving it if used
        logic publish;     // load the result register
    } bsc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic req_valid;
        logic full;
        logic free_at_p;
        logic pack_last;
        logic out_busy;
    } bsc_stat_t;

endpackage

### design/bsc_req_if.sv
// Request channel: one operation beat with valid/ready handshake.
interface bsc_req_if import bsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

### design/bsc_rsp_if.sv
// Result channel: one result beat with valid/ready handshake.
interface bsc_rsp_if import bsc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                full_res;
    logic                empty_res;

    modport source (output valid, output status, output slot, output full_res,
                    output empty_res, input ready);
    modport sink   (input valid, input status, input slot, input full_res,
                    input empty_res, output ready);
endinterface

### design/bsc_ctrl.sv
// Controller: sequences accept, dispatch, insert walk, compaction and result.
module bsc_ctrl import bsc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  bsc_stat_t stat,
    output bsc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_PACK,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                if (stat.op == OP_INSERT && !stat.full)
                begin
                    state_next = S_WALK;
                end
                else if (stat.op == OP_DEFRAG && !stat.full)
                begin
                    state_next = S_PACK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_WALK:
            begin
                if (stat.free_at_p)
                begin
                    cmd.walk_write = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_PACK:
            begin
                cmd.pack_step = 1'b1;
                if (stat.pack_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last block move lands in memory this cycle
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && stat.req_valid) |=> state_reg == S_DISPATCH)
        else $error("accepted beat not dispatched");
    a_pack_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PACK && stat.pack_last) |=> state_reg == S_DRAIN)
        else $error("compaction did not end in drain");
    a_finish_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && stat.out_busy) |=> state_reg == S_FINISH)
        else $error("result dropped while output busy");
`endif

endmodule

### design/bsc_datapath.sv
// Datapath: used flags, block memory, insert pointer, walk and pack counters, result register.
module bsc_datapath import bsc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  bsc_cmd_t     cmd,
    output bsc_stat_t    stat,
    bsc_req_if.sink      req,
    bsc_rsp_if.source    rsp
);

    // Block memory, written at one address per cycle
    data_t mem [BLOCKS];

    used_t   used_reg;
    used_t   used_next;
    idx_t    ptr_reg;
    idx_t    p_reg;
    idx_t    i_reg;
    cnt_t    dst_reg;
    logic    mv_pend_reg;
    idx_t    mv_addr_reg;
    data_t   rd_reg;
    logic    out_valid_reg;

    op_t                       op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]          position_reg;
    status_t                   res_status_reg;
    logic [SLOT_W-1:0]         res_slot_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic                      out_full_reg;
    logic                      out_empty_reg;

    logic  full;
    logic  empty;
    logic  accept;
    logic  del_in_range;
    idx_t  del_idx;
    logic  del_ok;
    data_t wr_data;
    logic  wr_nz;
    cnt_t  dst_dec;
    idx_t  dst_m1;
    idx_t  p_inc;

    status_t           disp_status;
    logic [SLOT_W-1:0] disp_slot;

    assign full    = &used_reg;
    assign empty   = ~|used_reg;
    assign accept  = req.valid && cmd.ready;

    // Delete checks on the latched position
    assign del_in_range = (position_reg != '0) && (position_reg <= POS_W'(BLOCKS));
    assign del_idx      = IDX_W'(position_reg - POS_W'(1));
    assign del_ok       = !empty && del_in_range && used_reg[del_idx];

    // Insert data, sign-extended or cut to the block width
    assign wr_data = DATA_WIDTH'(value_reg);
    assign wr_nz   = (wr_data != '0);

    assign dst_dec = dst_reg - CNT_W'(1);
    assign dst_m1  = dst_dec[IDX_W-1:0];
    assign p_inc   = (p_reg == IDX_W'(BLOCKS - 1)) ? '0 : p_reg + IDX_W'(1);

    // Status toward the controller
    assign stat.op        = op_reg;
    assign stat.req_valid = req.valid;
    assign stat.full      = full;
    assign stat.free_at_p = !used_reg[p_reg];
    assign stat.pack_last = (i_reg == '0);
    assign stat.out_busy  = out_valid_reg && !rsp.ready;

    assign req.ready     = cmd.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.slot      = out_slot_reg;
    assign rsp.full_res  = out_full_reg;
    assign rsp.empty_res = out_empty_reg;

    // Status and slot decided at dispatch
    always_comb
    begin
        disp_status = ST_OK;
        disp_slot   = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    disp_status = ST_FULL;
                end
            end
            OP_DELETE:
            begin
                if (empty)
                begin
                    disp_status = ST_EMPTY;
                end
                else if (!del_in_range)
                begin
                    disp_status = ST_BAD_POS;
                end
                else if (!used_reg[del_idx])
                begin
                    disp_status = ST_ALREADY_FREE;
                end
                else
                begin
                    disp_slot = SLOT_W'(del_idx);
                end
            end
            default:
            begin
                disp_status = ST_OK;
            end
        endcase
    end

    // Used flags next value
    always_comb
    begin
        used_next = used_reg;
        if (cmd.dispatch && op_reg == OP_DELETE && del_ok)
        begin
            used_next[del_idx] = 1'b0;
        end
        if (cmd.walk_write)
        begin
            used_next[p_reg] = wr_nz;
        end
        if (cmd.pack_step && used_reg[i_reg])
        begin
            used_next[i_reg]  = 1'b0;
            used_next[dst_m1] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            ptr_reg       <= '0;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            mv_pend_reg <= cmd.pack_step && used_reg[i_reg];
            if (cmd.dispatch && op_reg == OP_DEFRAG && !full)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.walk_write)
            begin
                ptr_reg <= p_reg;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload, counters and staged result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_t'(req.op);
            value_reg    <= req.value;
            position_reg <= req.position;
        end
        if (cmd.dispatch)
        begin
            p_reg          <= ptr_reg;
            i_reg          <= IDX_W'(BLOCKS - 1);
            dst_reg        <= CNT_W'(BLOCKS);
            res_status_reg <= disp_status;
            res_slot_reg   <= disp_slot;
        end
        else if (cmd.walk_write)
        begin
            res_slot_reg <= SLOT_W'(p_reg);
        end
        if (cmd.walk_step)
        begin
            p_reg <= p_inc;
        end
        if (cmd.pack_step)
        begin
            i_reg <= i_reg - IDX_W'(1);
            if (used_reg[i_reg])
            begin
                dst_reg     <= dst_dec;
                mv_addr_reg <= dst_m1;
            end
        end
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_full_reg   <= full;
            out_empty_reg  <= empty;
        end
    end

    // Block memory: insert write, or move write in the cycle after its read
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[i_reg];
        if (cmd.walk_write)
        begin
            mem[p_reg] <= wr_data;
        end
        else if (mv_pend_reg)
        begin
            mem[mv_addr_reg] <= rd_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_pack_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pack_step |=> $countones(used_reg) == $past($countones(used_reg)))
        else $error("compaction changed the number of used blocks");
    a_walk_hits_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_write |-> !used_reg[p_reg])
        else $error("insert wrote over a used block");
    a_pack_dst_above: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pack_step |-> dst_reg > {1'b0, i_reg})
        else $error("pack destination fell below the scan index");
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published result not presented");
`endif

endmodule

### design/block_store_compactor_unit.sv
// Steps from request beat to result register: a delete, no-op, refused op or defragment of a full
// store goes through dispatch to finish; an insert walks the blocks from the insert pointer to the
// first free one, then writes it; a defragment of a store that is not full scans every block from the
// top, moving each used one, then drains. One item at a time: the next beat is taken the cycle after
// the result is loaded, so an item also waits while the previous result is held on the output.
// Asynchronous active-low reset: all blocks free, insert pointer at block 0, no result.
module block_store_compactor_unit import bsc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bsc_req_if.sink   req,
    bsc_rsp_if.source rsp
);

    bsc_cmd_t  cmd;
    bsc_stat_t stat;

    // Sequencer
    bsc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage and result path
    bsc_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
